>>> src/bcs_pkg.sv
// Shared types, constants and step tables for the B-spline curve subdivider.
// Used by bcs_ctrl, bcs_datapath and bspline_curve_subdivider_unit; depends on nothing.

package bcs_pkg;

  localparam int COORD_WIDTH = 24;
  localparam int DATA_W = ((2 * COORD_WIDTH + 7) / 8) * 8;
  localparam int SUB_W = 5;
  localparam logic [SUB_W-1:0] SUB_MIN = 5'd8;
  localparam logic [SUB_W-1:0] SUB_MAX = 5'd21;
  localparam logic [SUB_W-1:0] SUB_RESET = 5'd8;

  localparam int T_W = 16;
  localparam int P_W = 17;
  localparam int W_W = 21;
  localparam int PROD_W = COORD_WIDTH + W_W;
  localparam int SUM_W = COORD_WIDTH + 24;
  localparam int SUM_SHIFT = 17;
  localparam int U_W = COORD_WIDTH + 3;
  localparam int RECIP_SHIFT = COORD_WIDTH + 4;
  localparam int RECIP_W = COORD_WIDTH + 3;
  localparam int Q_W = U_W + RECIP_W - RECIP_SHIFT;
  localparam int D_W = COORD_WIDTH + 3;

  localparam logic [RECIP_W-1:0] RECIP_MUL =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd2) / 64'd3);
  localparam logic signed [SUM_W-1:0] SUM_BIAS =
    SUM_W'(64'd196608 + (64'd3 << (COORD_WIDTH + 18)));
  localparam logic signed [D_W-1:0] Q_OFS = D_W'(64'd1 << (COORD_WIDTH + 1));
  localparam logic signed [D_W-1:0] COORD_MAX_EXT =
    D_W'((64'd1 << (COORD_WIDTH - 1)) - 64'd1);
  localparam logic signed [D_W-1:0] COORD_MIN_EXT = -COORD_MAX_EXT - D_W'(1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEG,
    ST_DRAIN,
    ST_ENDPT,
    ST_FLUSH
  } ctrl_state_t;

  typedef struct packed {
    logic byp;
    logic eor;
    logic eoc;
  } tag_t;

  typedef struct packed {
    logic load;
    logic fill;
    logic seg_start;
    logic issue;
    logic shift;
    tag_t tag;
  } dp_cmd_t;

  typedef struct packed {
    logic advance;
    logic pipe_empty;
    logic seg_last;
  } dp_sts_t;

  // Integer part of 65536 / s for every valid sample count.
  function automatic logic [T_W-1:0] step_quot(input logic [SUB_W-1:0] s);
    logic [T_W-1:0] q;
    unique case (s)
      5'd8:    q = 16'd8192;
      5'd9:    q = 16'd7281;
      5'd10:   q = 16'd6553;
      5'd11:   q = 16'd5957;
      5'd12:   q = 16'd5461;
      5'd13:   q = 16'd5041;
      5'd14:   q = 16'd4681;
      5'd15:   q = 16'd4369;
      5'd16:   q = 16'd4096;
      5'd17:   q = 16'd3855;
      5'd18:   q = 16'd3640;
      5'd19:   q = 16'd3449;
      5'd20:   q = 16'd3276;
      5'd21:   q = 16'd3120;
      default: q = 16'd8192;
    endcase
    return q;
  endfunction

  // Remainder of 65536 / s for every valid sample count.
  function automatic logic [SUB_W-1:0] step_rem(input logic [SUB_W-1:0] s);
    logic [SUB_W-1:0] r;
    unique case (s)
      5'd8:    r = 5'd0;
      5'd9:    r = 5'd7;
      5'd10:   r = 5'd6;
      5'd11:   r = 5'd9;
      5'd12:   r = 5'd4;
      5'd13:   r = 5'd3;
      5'd14:   r = 5'd2;
      5'd15:   r = 5'd1;
      5'd16:   r = 5'd0;
      5'd17:   r = 5'd1;
      5'd18:   r = 5'd16;
      5'd19:   r = 5'd5;
      5'd20:   r = 5'd16;
      5'd21:   r = 5'd16;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

>>> src/bspline_curve_subdivider_unit.sv
// Top level of the uniform cubic B-spline curve subdivider.
// Depends on bcs_pkg, bcs_ctrl and bcs_datapath.
//
//   channel  direction  handshake               payload
//   in       slave      in_tvalid / in_tready   in_tdata, in_tlast
//   out      master     out_tvalid / out_tready out_tdata, out_tlast, out_tuser
//   cfg      slave      cfg_valid / cfg_ready   cfg_data
//
// A point that starts a route yields no sample. Each segment issues 8 to 21 samples,
// one per cycle while the output does not stall, then waits for the basis pipeline
// to drain before the window shifts; a final point adds two segments and the
// endpoint. Reset is synchronous and active low. A stall on the output freezes the
// whole pipeline, and a new item is taken only once the previous one has drained.

module bspline_curve_subdivider_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bcs_pkg::SUB_W-1:0]         cfg_data,   // subdivisions
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [bcs_pkg::DATA_W-1:0]        in_tdata,   // point_x, point_y
  input  logic                              in_tlast,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [bcs_pkg::DATA_W-1:0]        out_tdata,  // curve_x, curve_y
  output logic                              out_tlast,
  output logic                              out_tuser   // end_of_curve
);

  bcs_pkg::dp_cmd_t cmd;
  bcs_pkg::dp_sts_t sts;

  assign cfg_ready = 1'b1;

  bcs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tlast  (in_tlast),
    .sts       (sts),
    .cmd       (cmd)
  );

  bcs_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

>>> src/bcs_datapath.sv
// Datapath: window registers, parameter generator, basis pipeline and output register.
// Depends on bcs_pkg; driven by bcs_ctrl through dp_cmd_t and reports dp_sts_t.

module bcs_datapath (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    cfg_valid,
  input  logic [bcs_pkg::SUB_W-1:0]               cfg_data,
  input  logic [bcs_pkg::DATA_W-1:0]              in_tdata,
  input  bcs_pkg::dp_cmd_t                        cmd,
  output bcs_pkg::dp_sts_t                        sts,
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  output logic [bcs_pkg::DATA_W-1:0]              out_tdata,
  output logic                                    out_tlast,
  output logic                                    out_tuser
);

  localparam int CW = bcs_pkg::COORD_WIDTH;

  logic [bcs_pkg::SUB_W-1:0] sub_r;
  logic [bcs_pkg::SUB_W-1:0] s_eff;

  logic signed [CW-1:0] win_x_r [3];
  logic signed [CW-1:0] win_y_r [3];
  logic signed [CW-1:0] px_r;
  logic signed [CW-1:0] py_r;
  logic signed [CW-1:0] in_x;
  logic signed [CW-1:0] in_y;

  logic [bcs_pkg::SUB_W-1:0] k_r;
  logic [bcs_pkg::T_W-1:0]   tq_r;
  logic [bcs_pkg::SUB_W-1:0] rm_r;
  logic [bcs_pkg::SUB_W:0]   rm_sum;
  logic                      rm_carry;
  logic [bcs_pkg::T_W-1:0]   tq_nxt;
  logic [bcs_pkg::SUB_W-1:0] rm_nxt;

  logic                      en;
  logic [6:0]                vld_r;
  bcs_pkg::tag_t             tag_r [7];

  logic [bcs_pkg::T_W-1:0]   t1_r;
  logic [bcs_pkg::T_W-1:0]   t2_r;
  logic [bcs_pkg::P_W-1:0]   sq2_r;
  logic [bcs_pkg::T_W-1:0]   t3_r;
  logic [bcs_pkg::P_W-1:0]   sq3_r;
  logic [bcs_pkg::P_W-1:0]   cu3_r;
  logic [32:0]               sq_nxt;
  logic [33:0]               cu_nxt;

  logic signed [bcs_pkg::W_W-1:0] ts;
  logic signed [bcs_pkg::W_W-1:0] s2;
  logic signed [bcs_pkg::W_W-1:0] s3;
  logic signed [bcs_pkg::W_W-1:0] w_nxt [4];
  logic signed [bcs_pkg::W_W-1:0] w_r [4];

  logic signed [bcs_pkg::PROD_W-1:0] prx_r [4];
  logic signed [bcs_pkg::PROD_W-1:0] pry_r [4];
  logic signed [CW-1:0]              pt_x [4];
  logic signed [CW-1:0]              pt_y [4];

  logic signed [bcs_pkg::SUM_W-1:0] sumx_nxt;
  logic signed [bcs_pkg::SUM_W-1:0] sumy_nxt;
  logic [bcs_pkg::U_W-1:0]          ux_r;
  logic [bcs_pkg::U_W-1:0]          uy_r;

  logic [bcs_pkg::U_W+bcs_pkg::RECIP_W-1:0] mx_nxt;
  logic [bcs_pkg::U_W+bcs_pkg::RECIP_W-1:0] my_nxt;
  logic [bcs_pkg::Q_W-1:0]                  qx_r;
  logic [bcs_pkg::Q_W-1:0]                  qy_r;

  logic                 out_valid_r;
  logic signed [CW-1:0] out_x_r;
  logic signed [CW-1:0] out_y_r;
  logic                 out_eor_r;
  logic                 out_eoc_r;

  function automatic logic signed [CW-1:0] to_coord(input logic [bcs_pkg::Q_W-1:0] q);
    logic signed [bcs_pkg::D_W-1:0] d;
    logic signed [CW-1:0]           v;
    d = $signed({1'b0, q}) - bcs_pkg::Q_OFS;
    if (d > bcs_pkg::COORD_MAX_EXT) begin
      v = bcs_pkg::COORD_MAX_EXT[CW-1:0];
    end else if (d < bcs_pkg::COORD_MIN_EXT) begin
      v = bcs_pkg::COORD_MIN_EXT[CW-1:0];
    end else begin
      v = d[CW-1:0];
    end
    return v;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_r <= bcs_pkg::SUB_RESET;
    end else if (cfg_valid) begin
      sub_r <= cfg_data;
    end
  end

  always_comb begin
    if (sub_r < bcs_pkg::SUB_MIN) begin
      s_eff = bcs_pkg::SUB_MIN;
    end else if (sub_r > bcs_pkg::SUB_MAX) begin
      s_eff = bcs_pkg::SUB_MAX;
    end else begin
      s_eff = sub_r;
    end
  end

  assign in_x = $signed(in_tdata[CW-1:0]);
  assign in_y = $signed(in_tdata[2*CW-1:CW]);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      px_r <= in_x;
      py_r <= in_y;
      if (cmd.fill) begin
        for (int i = 0; i < 3; i++) begin
          win_x_r[i] <= in_x;
          win_y_r[i] <= in_y;
        end
      end
    end else if (cmd.shift) begin
      win_x_r[0] <= win_x_r[1];
      win_x_r[1] <= win_x_r[2];
      win_x_r[2] <= px_r;
      win_y_r[0] <= win_y_r[1];
      win_y_r[1] <= win_y_r[2];
      win_y_r[2] <= py_r;
    end
  end

  // The parameter T = (k * 65536 + s / 2) / s advances by a quotient and remainder step.
  always_comb begin
    rm_sum   = {1'b0, rm_r} + {1'b0, bcs_pkg::step_rem(s_eff)};
    rm_carry = rm_sum >= {1'b0, s_eff};
    rm_nxt   = rm_carry ? 5'(rm_sum - {1'b0, s_eff}) : rm_sum[bcs_pkg::SUB_W-1:0];
    tq_nxt   = tq_r + bcs_pkg::step_quot(s_eff) + {15'd0, rm_carry};
  end

  always_ff @(posedge clk) begin
    if (cmd.seg_start) begin
      k_r  <= '0;
      tq_r <= '0;
      rm_r <= s_eff >> 1;
    end else if (cmd.issue) begin
      k_r  <= k_r + 5'd1;
      tq_r <= tq_nxt;
      rm_r <= rm_nxt;
    end
  end

  assign en = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[5:0], cmd.issue};
    end
  end

  always_comb begin
    sq_nxt = 33'(t1_r) * 33'(t1_r) + 33'd32768;
    cu_nxt = 34'(sq2_r) * 34'(t2_r) + 34'd32768;
    ts = $signed(bcs_pkg::W_W'(t3_r));
    s2 = $signed(bcs_pkg::W_W'(sq3_r));
    s3 = $signed(bcs_pkg::W_W'(cu3_r));
    w_nxt[0] = 21'sd65536 - 21'sd3 * ts + 21'sd3 * s2 - s3;
    w_nxt[1] = 21'sd262144 - 21'sd6 * s2 + 21'sd3 * s3;
    w_nxt[2] = 21'sd65536 + 21'sd3 * ts + 21'sd3 * s2 - 21'sd3 * s3;
    w_nxt[3] = s3;
    pt_x[0] = win_x_r[0];
    pt_x[1] = win_x_r[1];
    pt_x[2] = win_x_r[2];
    pt_x[3] = px_r;
    pt_y[0] = win_y_r[0];
    pt_y[1] = win_y_r[1];
    pt_y[2] = win_y_r[2];
    pt_y[3] = py_r;
    sumx_nxt = bcs_pkg::SUM_W'(prx_r[0]) + bcs_pkg::SUM_W'(prx_r[1])
             + bcs_pkg::SUM_W'(prx_r[2]) + bcs_pkg::SUM_W'(prx_r[3]) + bcs_pkg::SUM_BIAS;
    sumy_nxt = bcs_pkg::SUM_W'(pry_r[0]) + bcs_pkg::SUM_W'(pry_r[1])
             + bcs_pkg::SUM_W'(pry_r[2]) + bcs_pkg::SUM_W'(pry_r[3]) + bcs_pkg::SUM_BIAS;
    mx_nxt = (bcs_pkg::U_W + bcs_pkg::RECIP_W)'(ux_r)
           * (bcs_pkg::U_W + bcs_pkg::RECIP_W)'(bcs_pkg::RECIP_MUL);
    my_nxt = (bcs_pkg::U_W + bcs_pkg::RECIP_W)'(uy_r)
           * (bcs_pkg::U_W + bcs_pkg::RECIP_W)'(bcs_pkg::RECIP_MUL);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1_r     <= tq_r;
      tag_r[0] <= cmd.tag;
      t2_r     <= t1_r;
      sq2_r    <= sq_nxt[32:16];
      tag_r[1] <= tag_r[0];
      t3_r     <= t2_r;
      sq3_r    <= sq2_r;
      cu3_r    <= cu_nxt[32:16];
      tag_r[2] <= tag_r[1];
      for (int i = 0; i < 4; i++) begin
        w_r[i] <= w_nxt[i];
      end
      tag_r[3] <= tag_r[2];
      for (int i = 0; i < 4; i++) begin
        prx_r[i] <= bcs_pkg::PROD_W'(w_r[i]) * bcs_pkg::PROD_W'(pt_x[i]);
        pry_r[i] <= bcs_pkg::PROD_W'(w_r[i]) * bcs_pkg::PROD_W'(pt_y[i]);
      end
      tag_r[4] <= tag_r[3];
      ux_r     <= sumx_nxt[bcs_pkg::SUM_SHIFT+bcs_pkg::U_W-1:bcs_pkg::SUM_SHIFT];
      uy_r     <= sumy_nxt[bcs_pkg::SUM_SHIFT+bcs_pkg::U_W-1:bcs_pkg::SUM_SHIFT];
      tag_r[5] <= tag_r[4];
      qx_r     <= mx_nxt[bcs_pkg::U_W+bcs_pkg::RECIP_W-1:bcs_pkg::RECIP_SHIFT];
      qy_r     <= my_nxt[bcs_pkg::U_W+bcs_pkg::RECIP_W-1:bcs_pkg::RECIP_SHIFT];
      tag_r[6] <= tag_r[5];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld_r[6];
    end
  end

  always_ff @(posedge clk) begin
    if (en && vld_r[6]) begin
      out_x_r   <= tag_r[6].byp ? px_r : to_coord(qx_r);
      out_y_r   <= tag_r[6].byp ? py_r : to_coord(qy_r);
      out_eor_r <= tag_r[6].eor;
      out_eoc_r <= tag_r[6].eoc;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = bcs_pkg::DATA_W'({out_y_r, out_x_r});
  assign out_tlast  = out_eor_r;
  assign out_tuser  = out_eoc_r;

  assign sts.advance    = en;
  assign sts.pipe_empty = ~|vld_r;
  assign sts.seg_last   = k_r == 5'(s_eff - 5'd1);

endmodule

>>> src/bcs_ctrl.sv
// Controller state machine: sequences segments, window shifts and the endpoint.
// Depends on bcs_pkg; commands bcs_datapath through dp_cmd_t.

module bcs_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic             in_tlast,
  input  bcs_pkg::dp_sts_t sts,
  output bcs_pkg::dp_cmd_t cmd
);

  bcs_pkg::ctrl_state_t state_r;
  bcs_pkg::ctrl_state_t state_nxt;
  logic [1:0]           segs_r;
  logic [1:0]           segs_nxt;
  logic                 fin_r;
  logic                 fin_nxt;
  logic                 started_r;
  logic                 started_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= bcs_pkg::ST_IDLE;
      segs_r    <= '0;
      fin_r     <= 1'b0;
      started_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      segs_r    <= segs_nxt;
      fin_r     <= fin_nxt;
      started_r <= started_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    segs_nxt    = segs_r;
    fin_nxt     = fin_r;
    started_nxt = started_r;
    unique case (state_r)
      bcs_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          segs_nxt    = {in_tlast, started_r};
          fin_nxt     = in_tlast;
          started_nxt = !in_tlast;
          if (started_r || in_tlast) begin
            state_nxt = bcs_pkg::ST_SEG;
          end
        end
      end
      bcs_pkg::ST_SEG: begin
        if (sts.advance && sts.seg_last) begin
          segs_nxt  = segs_r - 2'd1;
          state_nxt = bcs_pkg::ST_DRAIN;
        end
      end
      bcs_pkg::ST_DRAIN: begin
        if (sts.pipe_empty) begin
          if (segs_r != 2'd0) begin
            state_nxt = bcs_pkg::ST_SEG;
          end else if (fin_r) begin
            state_nxt = bcs_pkg::ST_ENDPT;
          end else begin
            state_nxt = bcs_pkg::ST_IDLE;
          end
        end
      end
      bcs_pkg::ST_ENDPT: begin
        if (sts.advance) begin
          state_nxt = bcs_pkg::ST_FLUSH;
        end
      end
      bcs_pkg::ST_FLUSH: begin
        if (sts.pipe_empty) begin
          state_nxt = bcs_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bcs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      bcs_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load      = 1'b1;
          cmd.fill      = !started_r;
          cmd.seg_start = 1'b1;
        end
      end
      bcs_pkg::ST_SEG: begin
        if (sts.advance) begin
          cmd.issue   = 1'b1;
          cmd.tag.eor = !fin_r && segs_r == 2'd1 && sts.seg_last;
        end
      end
      bcs_pkg::ST_DRAIN: begin
        if (sts.pipe_empty) begin
          cmd.shift     = 1'b1;
          cmd.seg_start = 1'b1;
        end
      end
      bcs_pkg::ST_ENDPT: begin
        if (sts.advance) begin
          cmd.issue   = 1'b1;
          cmd.tag.byp = 1'b1;
          cmd.tag.eor = 1'b1;
          cmd.tag.eoc = 1'b1;
        end
      end
      bcs_pkg::ST_FLUSH: begin
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  a_shift_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.shift |-> sts.pipe_empty)
    else $error("window shifted while samples were still in the pipeline");

  a_issue_advance: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue |-> sts.advance)
    else $error("sample issued while the pipeline was stalled");

  a_final_segs: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && started_r && in_tlast) |=> segs_r == 2'd3)
    else $error("final point of a started route did not schedule three segments");

  a_endpt_flag: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.tag.eoc |-> (cmd.tag.byp && fin_r))
    else $error("curve end flag outside the endpoint of a final item");
`endif

endmodule

>>> bench/tb_top.sv
// Self-checking bench for bspline_curve_subdivider_unit: routes of control points with
// random stalls on both streams, checked sample by sample against a B-spline predictor class.
// Depends on bcs_pkg and the RTL under src.
`timescale 1ns / 100ps

module tb_top;

  localparam int CW = bcs_pkg::COORD_WIDTH;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 30;
  localparam int PHASE_POINTS = 42;
  localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};

  typedef struct {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    bit                   eor;
    bit                   eoc;
  } curve_sample_t;

  class curve_checker;
    curve_sample_t                 pending_samples[$];
    longint                        win_x[3];
    longint                        win_y[3];
    bit                            started;
    logic [bcs_pkg::SUB_W-1:0]     subdivisions;
    int                            errors;

    function new();
      foreach (win_x[i]) begin
        win_x[i] = 0;
        win_y[i] = 0;
      end
      started = 0;
      subdivisions = bcs_pkg::SUB_RESET;
      errors = 0;
    endfunction

    function void set_subdivisions(logic [bcs_pkg::SUB_W-1:0] v);
      subdivisions = v;
    endfunction

    function logic signed [CW-1:0] saturate(longint v);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (CW - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) v = hi;
      if (v < lo) v = lo;
      return v[CW-1:0];
    endfunction

    function longint basis_sum(longint w[4], longint p[4]);
      longint num;
      longint den;
      num = w[0] * p[0] + w[1] * p[1] + w[2] * p[2] + w[3] * p[3] + 3 * 65536;
      den = 6 * 65536;
      if (num >= 0) return num / den;
      return -((-num + den - 1) / den);
    endfunction

    function void push_sample(longint x, longint y, bit eor, bit eoc);
      curve_sample_t s;
      s.x = saturate(x);
      s.y = saturate(y);
      s.eor = eor;
      s.eoc = eoc;
      pending_samples = {pending_samples, s};
    endfunction

    // Emits one segment for the window plus the new point, then shifts the point in.
    function void emit_window(longint x, longint y);
      longint sub;
      longint tq;
      longint t2;
      longint t3;
      longint w[4];
      longint px[4];
      longint py[4];
      sub = subdivisions;
      if (sub < bcs_pkg::SUB_MIN) sub = bcs_pkg::SUB_MIN;
      if (sub > bcs_pkg::SUB_MAX) sub = bcs_pkg::SUB_MAX;
      px = '{win_x[0], win_x[1], win_x[2], x};
      py = '{win_y[0], win_y[1], win_y[2], y};
      for (longint k = 0; k < sub; k++) begin
        tq = (k * 65536 + sub / 2) / sub;
        t2 = (tq * tq + 32768) >>> 16;
        t3 = (t2 * tq + 32768) >>> 16;
        w[0] = 65536 - 3 * tq + 3 * t2 - t3;
        w[1] = 4 * 65536 - 6 * t2 + 3 * t3;
        w[2] = 65536 + 3 * tq + 3 * t2 - 3 * t3;
        w[3] = t3;
        push_sample(basis_sum(w, px), basis_sum(w, py), 0, 0);
      end
      win_x[0] = win_x[1]; win_x[1] = win_x[2]; win_x[2] = x;
      win_y[0] = win_y[1]; win_y[1] = win_y[2]; win_y[2] = y;
    endfunction

    function void take_point(logic signed [CW-1:0] x, logic signed [CW-1:0] y, bit fin);
      int     prior_count;
      longint lx;
      longint ly;
      prior_count = pending_samples.size();
      if (started) begin
        emit_window(longint'(x), longint'(y));
      end else begin
        foreach (win_x[i]) begin
          win_x[i] = longint'(x);
          win_y[i] = longint'(y);
        end
        started = 1;
      end
      if (fin) begin
        lx = win_x[2];
        ly = win_y[2];
        emit_window(lx, ly);
        emit_window(lx, ly);
        push_sample(lx, ly, 1, 1);
        foreach (win_x[i]) begin
          win_x[i] = 0;
          win_y[i] = 0;
        end
        started = 0;
      end else if (pending_samples.size() > prior_count) begin
        pending_samples[pending_samples.size() - 1].eor = 1;
      end
    endfunction

    task report_mismatch(string what);
      errors++;
      $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    task check_sample(logic [bcs_pkg::DATA_W-1:0] data, logic eor, logic eoc);
      curve_sample_t        want;
      logic signed [CW-1:0] got_x;
      logic signed [CW-1:0] got_y;
      got_x = data[CW-1:0];
      got_y = data[2*CW-1:CW];
      if (pending_samples.size() == 0) begin
        report_mismatch($sformatf("unexpected sample x=%0d y=%0d", got_x, got_y));
      end else begin
        want = pending_samples.pop_front();
        if (got_x !== want.x)
          report_mismatch($sformatf("curve_x got %0d want %0d", got_x, want.x));
        if (got_y !== want.y)
          report_mismatch($sformatf("curve_y got %0d want %0d", got_y, want.y));
        if (eor !== want.eor)
          report_mismatch($sformatf("end_of_run got %b want %b", eor, want.eor));
        if (eoc !== want.eoc)
          report_mismatch($sformatf("end_of_curve got %b want %b", eoc, want.eoc));
      end
    endtask
  endclass

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [bcs_pkg::SUB_W-1:0]     cfg_data;
  logic                          in_tvalid;
  logic                          in_tready;
  logic [bcs_pkg::DATA_W-1:0]    in_tdata;
  logic                          in_tlast;
  logic                          out_tvalid;
  logic                          out_tready;
  logic [bcs_pkg::DATA_W-1:0]    out_tdata;
  logic                          out_tlast;
  logic                          out_tuser;

  curve_checker sb = new();
  bit           in_steady;
  bit           out_steady;
  int           quiet_cycles;
  int           points_sent;

  bspline_curve_subdivider_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int pick_gap(int none_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < none_pct) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [CW-1:0] pick_coord();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return C_MAX;
      1: return C_MIN;
      2, 3, 4: return CW'($urandom());
      default: return CW'(int'($urandom_range(0, 40000)) - 20000);
    endcase
  endfunction

  task automatic send_point(logic signed [CW-1:0] x, logic signed [CW-1:0] y, bit fin);
    int gap;
    @(negedge clk);
    in_tdata  <= {y, x};
    in_tlast  <= fin;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.take_point(x, y, fin);
    points_sent++;
    gap = in_steady ? 0 : pick_gap(60);
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    while (sb.pending_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_subdivisions(logic [bcs_pkg::SUB_W-1:0] v);
    @(negedge clk);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_subdivisions(v);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_route(int len);
    for (int i = 0; i < len; i++)
      send_point(pick_coord(), pick_coord(), i == len - 1);
  endtask

  // Output stalls change only at the falling edge.
  initial begin
    int hold;
    hold = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (!rst_n) begin
        out_tready <= 1'b0;
      end else if (hold > 0) begin
        hold--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        hold = out_steady ? 0 : pick_gap(75);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready)
        sb.check_sample(out_tdata, out_tlast, out_tuser);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("** bspline_curve_subdivider_unit: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    logic [bcs_pkg::SUB_W-1:0] sub_plan[10];
    int                        phase_start;
    int                        len;
    sub_plan = '{5'd0, 5'd31, 5'd21, 5'd7, 5'd22, 5'd13, 5'd8, 5'd16, 5'd11, 5'd19};
    quiet_cycles = 0;
    points_sent = 0;
    in_steady = 0;
    out_steady = 0;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed routes at the reset sample count: extremes, one-point route,
    // short routes evaluated without passthrough, and a flat route at full scale.
    send_point(C_MAX, C_MAX, 0);
    send_point(C_MIN, C_MIN, 0);
    send_point(C_MAX, C_MIN, 0);
    send_point(C_MIN, C_MAX, 0);
    send_point('0, '0, 1);
    send_point(-1, 1, 1);
    send_point(123456, -654321, 0);
    send_point(-7, 7, 1);
    send_point(1000, -1000, 0);
    send_point(-2560, 2560, 0);
    send_point(300, 301, 1);
    send_point(0, 0, 0);
    send_point(256, 0, 0);
    send_point(256, 256, 0);
    send_point(0, 256, 1);
    send_point(C_MAX, C_MIN, 0);
    send_point(C_MAX, C_MIN, 0);
    send_point(C_MAX, C_MIN, 0);
    send_point(C_MAX, C_MIN, 1);

    foreach (sub_plan[p]) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      wait_drained();
      write_subdivisions(sub_plan[p]);
      in_steady = ($urandom_range(0, 3) == 0);
      out_steady = ($urandom_range(0, 3) == 0);
      phase_start = points_sent;
      while (points_sent - phase_start < PHASE_POINTS) begin
        len = ($urandom_range(0, 99) < 75) ? $urandom_range(4, 10) : $urandom_range(1, 3);
        send_route(len);
      end
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    wait_drained();
    if (sb.pending_samples.size() != 0)
      sb.report_mismatch($sformatf("%0d samples never arrived", sb.pending_samples.size()));
    if (sb.errors == 0)
      $display("** bspline_curve_subdivider_unit: PASSED **");
    else
      $display("** bspline_curve_subdivider_unit: FAILED **");
    $finish;
  end

endmodule

>>> sim.f
src/bcs_pkg.sv
src/bcs_datapath.sv
src/bcs_ctrl.sv
src/bspline_curve_subdivider_unit.sv
bench/tb_top.sv
